// ===== src/sldc_pkg.sv =====
package sldc_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;
  localparam logic [7:0] CMD_SET  = 8'h41;
  localparam logic [7:0] CMD_MODE = 8'h42;
  localparam logic [7:0] CMD_STOP = 8'h43;
  localparam logic [7:0] ASCII_0  = 8'h30;
  localparam logic [7:0] ASCII_1  = 8'h31;
  localparam logic [7:0] ASCII_9  = 8'h39;
  localparam logic [3:0] DIGIT_MAX = 4'd9;

  localparam logic [7:0] SEG_TABLE [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  typedef enum logic [2:0] {
    REQ_RX       = 3'd0,
    REQ_TICK     = 3'd1,
    REQ_UP       = 3'd2,
    REQ_DOWN     = 3'd3,
    REQ_STOP     = 3'd4,
    REQ_CNT_DOWN = 3'd5,
    REQ_CNT_UP   = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_CMD   = 2'd1,
    PH_DATA  = 2'd2,
    PH_END   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_UP   = 2'd1,
    MODE_DOWN = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    JOB_NONE = 2'd0,
    JOB_SET  = 2'd1,
    JOB_MODE = 2'd2,
    JOB_STOP = 2'd3
  } job_kind_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] rx_byte;
  } sldc_in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic [3:0] local_value;
    logic [3:0] remote_value;
    logic [1:0] remote_mode;
    logic [7:0] local_segments;
    logic [7:0] remote_segments;
  } sldc_out_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;
    logic [3:0] local_value;
    logic [3:0] remote_value;
    logic [1:0] remote_mode;
  } sldc_job_t;

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    if (d > DIGIT_MAX) begin
      s = 8'hFF;
    end else begin
      s = ~SEG_TABLE[d];
    end
    return s;
  endfunction

endpackage

// ===== src/sldc_front.sv =====
module sldc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  sldc_pkg::sldc_in_t  in_data,
  output logic                in_stall,
  input  logic                q_full,
  output logic                q_push,
  output sldc_pkg::sldc_job_t q_job
);
  import sldc_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] command, command_next;
  logic [7:0] payload, payload_next;
  logic [3:0] remote, remote_next;
  mode_t      mode, mode_next;
  logic [3:0] local_d, local_next;
  logic       done;
  job_kind_t  kind;
  logic [7:0] data;
  logic [7:0] b;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign b        = in_data.rx_byte;

  always_comb begin
    phase_next   = phase;
    command_next = command;
    payload_next = payload;
    remote_next  = remote;
    mode_next    = mode;
    local_next   = local_d;
    done         = 1'b0;
    kind         = JOB_NONE;
    data         = 8'h00;
    case (in_data.req_type)
      REQ_RX: begin
        case (phase)
          PH_START: begin
            if (b == STX_BYTE) phase_next = PH_CMD;
          end
          PH_CMD: begin
            if (b == ETX_BYTE) begin
              done       = 1'b1;
              phase_next = PH_START;
            end else begin
              command_next = b;
              phase_next   = PH_DATA;
            end
          end
          PH_DATA: begin
            if (b == ETX_BYTE) begin
              done       = 1'b1;
              phase_next = PH_START;
            end else begin
              payload_next = b;
              phase_next   = PH_END;
            end
          end
          default: begin
            done       = (b == ETX_BYTE);
            phase_next = PH_START;
          end
        endcase
      end
      REQ_TICK: begin
        if (mode == MODE_UP) begin
          remote_next = (remote >= DIGIT_MAX) ? 4'd0 : remote + 4'd1;
        end else if (mode == MODE_DOWN) begin
          remote_next = (remote == 4'd0 || remote > DIGIT_MAX) ? DIGIT_MAX : remote - 4'd1;
        end
      end
      REQ_UP: begin
        local_next = (local_d >= DIGIT_MAX) ? 4'd0 : local_d + 4'd1;
        kind       = JOB_SET;
        data       = ASCII_0 + {4'h0, local_next};
      end
      REQ_DOWN: begin
        local_next = (local_d == 4'd0 || local_d > DIGIT_MAX) ? DIGIT_MAX : local_d - 4'd1;
        kind       = JOB_SET;
        data       = ASCII_0 + {4'h0, local_next};
      end
      REQ_STOP: begin
        kind = JOB_STOP;
      end
      REQ_CNT_DOWN: begin
        kind = JOB_MODE;
        data = ASCII_1;
      end
      REQ_CNT_UP: begin
        kind = JOB_MODE;
        data = ASCII_0;
      end
      default: begin
      end
    endcase

    if (done) begin
      if (command == CMD_SET) begin
        if (payload >= ASCII_0 && payload <= ASCII_9) begin
          remote_next = 4'(payload - ASCII_0);
        end
      end else if (command == CMD_MODE) begin
        if (payload == ASCII_0) begin
          mode_next = MODE_UP;
        end else if (payload == ASCII_1) begin
          mode_next = MODE_DOWN;
        end else begin
          mode_next = MODE_STOP;
        end
      end else if (command == CMD_STOP) begin
        mode_next = MODE_STOP;
      end
    end

    q_job.kind         = kind;
    q_job.data         = data;
    q_job.local_value  = local_next;
    q_job.remote_value = remote_next;
    q_job.remote_mode  = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_START;
      command <= 8'h00;
      payload <= 8'h00;
      remote  <= 4'd0;
      mode    <= MODE_STOP;
      local_d <= 4'd0;
    end else if (q_push) begin
      phase   <= phase_next;
      command <= command_next;
      payload <= payload_next;
      remote  <= remote_next;
      mode    <= mode_next;
      local_d <= local_next;
    end
  end

endmodule

// ===== src/sldc_queue.sv =====
module sldc_queue #(
  parameter int DEPTH = sldc_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sldc_pkg::sldc_job_t push_job,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output sldc_pkg::sldc_job_t head_job
);
  import sldc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sldc_job_t       entries [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/sldc_back.sv =====
module sldc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  sldc_pkg::sldc_job_t head_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output sldc_pkg::sldc_out_t out_data
);
  import sldc_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       is_last;
  logic [7:0] letter;
  logic [7:0] tx_byte;

  assign load = head_valid && (!out_valid || !out_stall);
  assign pop  = load && is_last;

  always_comb begin
    case (head_job.kind)
      JOB_SET:  letter = CMD_SET;
      JOB_MODE: letter = CMD_MODE;
      JOB_STOP: letter = CMD_STOP;
      default:  letter = 8'h00;
    endcase
    case (head_job.kind)
      JOB_NONE: is_last = 1'b1;
      JOB_STOP: is_last = (idx == 2'd2);
      default:  is_last = (idx == 2'd3);
    endcase
    case (idx)
      2'd0:    tx_byte = STX_BYTE;
      2'd1:    tx_byte = letter;
      2'd2:    tx_byte = (head_job.kind == JOB_STOP) ? ETX_BYTE : head_job.data;
      default: tx_byte = ETX_BYTE;
    endcase
    if (head_job.kind == JOB_NONE) begin
      tx_byte = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= is_last ? 2'd0 : idx + 2'd1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.tx_valid        <= (head_job.kind != JOB_NONE);
      out_data.tx_byte         <= tx_byte;
      out_data.last            <= is_last;
      out_data.local_value     <= head_job.local_value;
      out_data.remote_value    <= head_job.remote_value;
      out_data.remote_mode     <= head_job.remote_mode;
      out_data.local_segments  <= seg_of(head_job.local_value);
      out_data.remote_segments <= seg_of(head_job.remote_value);
    end
  end

endmodule

// ===== src/serial_linked_digit_counter.sv =====
// One end of a serial link that shares two decimal digits. Each input item is a received
// byte, a counting tick or a local button event; received bytes run through an STX, command,
// data, ETX frame parser and a completed frame carries out the stored command, while button
// events step the local digit and send it, or send a mode or stop command, as a framed
// byte sequence. Received bytes and ticks give one result item each and can be taken one
// per cycle when not stalled; a button event gives three or four result items, one frame
// byte per cycle unless the output stalls. The output sequencer sets that rate, and a queue
// of QUEUE_DEPTH decoded events lets new items be taken while earlier frames are still being sent.
module serial_linked_digit_counter #(
  parameter int QUEUE_DEPTH = sldc_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sldc_pkg::sldc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sldc_pkg::sldc_out_t out_data
);
  import sldc_pkg::*;

  logic      q_full;
  logic      q_push;
  sldc_job_t q_job;
  logic      q_pop;
  logic      head_valid;
  sldc_job_t head_job;

  sldc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  sldc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  sldc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== tb/serial_linked_digit_counter_tb.sv =====
module serial_linked_digit_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sldc_pkg::*;

  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 205;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int HOLD_OFF_AFTER = 150;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [2:0] req;
    logic [7:0] data;
    logic       pinned;
    sldc_out_t  want;
  } item_row_t;

  localparam sldc_out_t AT_RESET = '{1'b0, 8'h00, 1'b1, 4'd0, 4'd0, MODE_STOP, 8'hC0, 8'hC0};

  localparam item_row_t DIRECTED [25] = '{
    '{REQ_TICK,     8'h00,    1'b1, AT_RESET},
    '{REQ_UNUSED,   8'hFF,    1'b1, AT_RESET},
    '{REQ_RX,       8'hFF,    1'b1, AT_RESET},
    '{REQ_RX,       8'h00,    1'b1, AT_RESET},
    '{REQ_UP,       8'h00,    1'b0, '0},
    '{REQ_DOWN,     8'h00,    1'b0, '0},
    '{REQ_DOWN,     8'h00,    1'b0, '0},
    '{REQ_UP,       8'h00,    1'b0, '0},
    '{REQ_STOP,     8'h00,    1'b0, '0},
    '{REQ_CNT_DOWN, 8'h00,    1'b0, '0},
    '{REQ_CNT_UP,   8'h00,    1'b0, '0},
    '{REQ_RX,       STX_BYTE, 1'b0, '0},
    '{REQ_RX,       CMD_SET,  1'b0, '0},
    '{REQ_RX,       8'h3A,    1'b0, '0},
    '{REQ_RX,       ETX_BYTE, 1'b0, '0},
    '{REQ_RX,       STX_BYTE, 1'b0, '0},
    '{REQ_RX,       CMD_MODE, 1'b0, '0},
    '{REQ_RX,       ASCII_1,  1'b0, '0},
    '{REQ_RX,       ETX_BYTE, 1'b0, '0},
    '{REQ_TICK,     8'h00,    1'b0, '0},
    '{REQ_RX,       STX_BYTE, 1'b0, '0},
    '{REQ_RX,       CMD_STOP, 1'b0, '0},
    '{REQ_RX,       ETX_BYTE, 1'b0, '0},
    '{REQ_RX,       STX_BYTE, 1'b0, '0},
    '{REQ_RX,       ETX_BYTE, 1'b0, '0}
  };

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  sldc_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  sldc_out_t out_data;

  item_row_t item_plan [$];
  sldc_out_t pending_out [$];
  int        errors = 0;
  int        sent = 0;
  int        gap_left = 0;
  int        burst_left = 1;
  int        results_taken = 0;
  int        hold_left = 0;
  bit        held_off = 1'b0;
  int        stall_step = 0;
  int        cycles = 0;

  phase_t     parse_phase;
  logic [7:0] kept_command;
  logic [7:0] kept_payload;
  logic [3:0] remote_digit;
  logic [3:0] local_digit;
  mode_t      count_mode;

  serial_linked_digit_counter DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic add_item(input logic [2:0] req, input logic [7:0] data);
    item_row_t r;
    r = '0;
    r.req = req;
    r.data = data;
    item_plan.push_back(r);
  endtask

  task automatic run_kept_command();
    if (kept_command == CMD_SET) begin
      if (kept_payload >= ASCII_0 && kept_payload <= ASCII_9) begin
        remote_digit = 4'(kept_payload - ASCII_0);
      end
    end else if (kept_command == CMD_MODE) begin
      if (kept_payload == ASCII_0) begin
        count_mode = MODE_UP;
      end else if (kept_payload == ASCII_1) begin
        count_mode = MODE_DOWN;
      end else begin
        count_mode = MODE_STOP;
      end
    end else if (kept_command == CMD_STOP) begin
      count_mode = MODE_STOP;
    end
  endtask

  task automatic forecast_item(input item_row_t r);
    logic [7:0] frame [4];
    int         n;
    int         cnt;
    logic       done;
    sldc_out_t  o;
    n = 0;
    done = 1'b0;
    case (r.req)
      REQ_RX: begin
        case (parse_phase)
          PH_START: begin
            if (r.data == STX_BYTE) parse_phase = PH_CMD;
          end
          PH_CMD: begin
            if (r.data == ETX_BYTE) begin
              done = 1'b1;
              parse_phase = PH_START;
            end else begin
              kept_command = r.data;
              parse_phase = PH_DATA;
            end
          end
          PH_DATA: begin
            if (r.data == ETX_BYTE) begin
              done = 1'b1;
              parse_phase = PH_START;
            end else begin
              kept_payload = r.data;
              parse_phase = PH_END;
            end
          end
          default: begin
            done = (r.data == ETX_BYTE);
            parse_phase = PH_START;
          end
        endcase
        if (done) run_kept_command();
      end
      REQ_TICK: begin
        if (count_mode == MODE_UP) begin
          remote_digit = (remote_digit >= DIGIT_MAX) ? 4'd0 : remote_digit + 4'd1;
        end else if (count_mode == MODE_DOWN) begin
          remote_digit = (remote_digit == 4'd0) ? DIGIT_MAX : remote_digit - 4'd1;
        end
      end
      REQ_UP, REQ_DOWN: begin
        if (r.req == REQ_UP) begin
          local_digit = (local_digit >= DIGIT_MAX) ? 4'd0 : local_digit + 4'd1;
        end else begin
          local_digit = (local_digit == 4'd0) ? DIGIT_MAX : local_digit - 4'd1;
        end
        frame = '{STX_BYTE, CMD_SET, ASCII_0 + 8'(local_digit), ETX_BYTE};
        n = 4;
      end
      REQ_STOP: begin
        frame = '{STX_BYTE, CMD_STOP, ETX_BYTE, 8'h00};
        n = 3;
      end
      REQ_CNT_DOWN, REQ_CNT_UP: begin
        frame = '{STX_BYTE, CMD_MODE, (r.req == REQ_CNT_DOWN) ? ASCII_1 : ASCII_0, ETX_BYTE};
        n = 4;
      end
      default: begin
      end
    endcase
    cnt = (n > 0) ? n : 1;
    for (int k = 0; k < cnt; k++) begin
      o.tx_valid = (n > 0);
      o.tx_byte = (n > 0) ? frame[k] : 8'h00;
      o.last = (k == cnt - 1);
      o.local_value = local_digit;
      o.remote_value = remote_digit;
      o.remote_mode = count_mode;
      o.local_segments = ~SEG_TABLE[local_digit];
      o.remote_segments = ~SEG_TABLE[remote_digit];
      pending_out.push_back(o);
    end
    if (r.pinned) pending_out[pending_out.size() - 1] = r.want;
  endtask

  task automatic report_field(input string name, input logic [7:0] want_v,
                              input logic [7:0] got_v);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
    errors++;
  endtask

  task automatic check_result(input sldc_out_t got);
    sldc_out_t want;
    if (pending_out.size() == 0) begin
      $display("%0t: result with nothing expected, expected none, got %p", $time, got);
      errors++;
    end else begin
      want = pending_out.pop_front();
      if (got.tx_valid !== want.tx_valid) begin
        report_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
      end
      if (got.tx_byte !== want.tx_byte) report_field("tx_byte", want.tx_byte, got.tx_byte);
      if (got.last !== want.last) begin
        report_field("last", 8'(want.last), 8'(got.last));
      end
      if (got.local_value !== want.local_value) begin
        report_field("local_value", 8'(want.local_value), 8'(got.local_value));
      end
      if (got.remote_value !== want.remote_value) begin
        report_field("remote_value", 8'(want.remote_value), 8'(got.remote_value));
      end
      if (got.remote_mode !== want.remote_mode) begin
        report_field("remote_mode", 8'(want.remote_mode), 8'(got.remote_mode));
      end
      if (got.local_segments !== want.local_segments) begin
        report_field("local_segments", want.local_segments, got.local_segments);
      end
      if (got.remote_segments !== want.remote_segments) begin
        report_field("remote_segments", want.remote_segments, got.remote_segments);
      end
    end
  endtask

  // Most random traffic is framed so that the parser gets past its first phase.
  task automatic build_random_items();
    int         pick;
    int         sel;
    int         shape;
    logic [7:0] cmd;
    logic [7:0] data;
    while (item_plan.size() < RANDOM_ITEMS + $size(DIRECTED)) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        sel = $urandom_range(0, 9);
        cmd = (sel < 3) ? CMD_SET : (sel < 6) ? CMD_MODE : (sel < 8) ? CMD_STOP
                                                                   : 8'($urandom_range(0, 255));
        sel = $urandom_range(0, 9);
        data = (sel < 5) ? ASCII_0 + 8'($urandom_range(0, 9))
             : (sel < 8) ? ASCII_0 + 8'($urandom_range(0, 1)) : 8'($urandom_range(0, 255));
        shape = $urandom_range(0, 9);
        add_item(REQ_RX, STX_BYTE);
        if (shape < 7) begin
          add_item(REQ_RX, cmd);
          add_item(REQ_RX, data);
          add_item(REQ_RX, ETX_BYTE);
        end else if (shape == 7) begin
          add_item(REQ_RX, ETX_BYTE);
        end else if (shape == 8) begin
          add_item(REQ_RX, cmd);
          add_item(REQ_RX, ETX_BYTE);
        end else begin
          add_item(REQ_RX, cmd);
          add_item(REQ_RX, data);
          add_item(REQ_RX, 8'($urandom_range(0, 255)));
        end
      end else if (pick < 70) begin
        add_item(REQ_TICK, 8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        add_item(3'($urandom_range(REQ_UP, REQ_CNT_UP)), 8'($urandom_range(0, 255)));
      end else begin
        add_item(3'($urandom_range(REQ_RX, REQ_UNUSED)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        forecast_item(item_plan[sent]);
        sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0 || sent >= item_plan.size()) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          in_valid <= 1'b1;
          in_data <= {item_plan[sent].req, item_plan[sent].data};
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
        results_taken++;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!held_off && results_taken >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
        out_stall <= 1'b1;
      end else begin
        stall_step++;
        case ((stall_step / 50) % 4)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 1);
          2: out_stall <= (stall_step % 3 == 0);
          default: out_stall <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    parse_phase = PH_START;
    kept_command = 8'h00;
    kept_payload = 8'h00;
    remote_digit = 4'd0;
    local_digit = 4'd0;
    count_mode = MODE_STOP;
    foreach (DIRECTED[i]) item_plan.push_back(DIRECTED[i]);
    build_random_items();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (sent == item_plan.size() && pending_out.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== serial_linked_digit_counter.f =====
src/sldc_pkg.sv
src/sldc_front.sv
src/sldc_queue.sv
src/sldc_back.sv
src/serial_linked_digit_counter.sv
tb/serial_linked_digit_counter_tb.sv
